@@ hw/rtl/pointing_matrix_to_encoder_macros.svh @@
// assertion helpers shared by the pointing pipeline, clocked on clk, held off in reset
`ifndef POINTING_MATRIX_TO_ENCODER_MACROS_SVH
`define POINTING_MATRIX_TO_ENCODER_MACROS_SVH

// condition that holds at every clock edge
`define PM_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// implication checked in the same cycle
`define PM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/pmenc_pkg.sv @@
package pmenc_pkg;

  // datapath width for angles and vector components, Q30
  localparam int CW = 38;
  // degree width, Q30
  localparam int DW = 45;

  localparam logic signed [CW-1:0] ONE_Q30     = 38'sd1073741824;
  localparam logic signed [CW-1:0] PI_Q30      = 38'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 38'sd1686629713;
  localparam logic signed [CW-1:0] TWO_PI_Q30  = 38'sd6746518852;
  localparam logic signed [CW-1:0] GAIN_Q30    = 38'sd652032874;
  localparam logic signed [26:0]   R2D_Q20     = 27'sd60078979;
  localparam logic signed [DW-1:0] DEG180_Q30  = 45'sd193273528320;
  localparam logic signed [DW-1:0] DEG360_Q30  = 45'sd386547056640;

  typedef enum logic [3:0] {
    CFG_ROW_X     = 4'd0,
    CFG_ROW_Y     = 4'd1,
    CFG_ROW_Z     = 4'd2,
    CFG_RA_LIMIT  = 4'd3,
    CFG_POLE_OFFS = 4'd4,
    CFG_SOUTHERN  = 4'd5,
    CFG_SCALE     = 4'd6,
    CFG_OFFSETS   = 4'd7
  } cfg_reg_t;

  // arctan(2^-k) in Q30
  function automatic logic [29:0] atan_q30(input int k);
    logic [29:0] v;
    case (k)
      0: v = 30'd843314857;
      1: v = 30'd497837829;
      2: v = 30'd263043837;
      3: v = 30'd133525159;
      4: v = 30'd67021687;
      5: v = 30'd33543516;
      6: v = 30'd16775851;
      7: v = 30'd8388437;
      8: v = 30'd4194283;
      9: v = 30'd2097149;
      default: v = (k >= 10 && k <= 30) ? (30'd1 << (30 - k)) : 30'd0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/pointing_matrix_to_encoder.sv @@
// Pointing model: target hour angle and declination to RA and Dec encoder steps.
// in_* : one item per handshake, hour angle and declination in radians, Q3.28.
// out_*: one item per input item, in the same order: both encoder counts, saturated
//        to 32 bits, and the number of axis flips taken (0..2).
// cfg_*: register writes, always ready; write only while no item is in flight.
// Input to output runs through the sin/cos CORDIC, the 31-step square root and the
// angle CORDIC in series. Throughput is one item per cycle while out_tready does not
// stall the pipeline; every stage is registered and carries a valid bit.
// Reset clears the valid bits and loads the register defaults (fixed default matrix
// rows, 180 degree RA limit, zero scales and offsets); no clearing pass is needed.
// When the receiver holds out_tready low with a result waiting, the whole pipeline
// freezes and in_tready drops in the same cycle; nothing is lost or repeated.
`include "pointing_matrix_to_encoder_macros.svh"

module pointing_matrix_to_encoder #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] hour_angle, [63:32] declination
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [31:0] ra_encoder, [63:32] dec_encoder, [65:64] flip_count
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import pmenc_pkg::*;

  localparam int SQ_TAG_W = 2 * CW + 32;

  // configuration registers
  logic [62:0]        row_x_r, row_y_r, row_z_r;
  logic signed [25:0] ra_limit_r, pole_r;
  logic               south_r;
  logic [63:0]        scale_r, offs_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_x_r    <= 63'h7FFF_FC00_0000_0000;
      row_y_r    <= 63'h0000_0200_0008_0000;
      row_z_r    <= 63'h0000_0000_0008_0000;
      ra_limit_r <= 26'sd11796480;
      pole_r     <= '0;
      south_r    <= 1'b0;
      scale_r    <= '0;
      offs_r     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ROW_X:     row_x_r    <= cfg_data[62:0];
        CFG_ROW_Y:     row_y_r    <= cfg_data[62:0];
        CFG_ROW_Z:     row_z_r    <= cfg_data[62:0];
        CFG_RA_LIMIT:  ra_limit_r <= signed'(cfg_data[25:0]);
        CFG_POLE_OFFS: pole_r     <= signed'(cfg_data[25:0]);
        CFG_SOUTHERN:  south_r    <= cfg_data[0];
        CFG_SCALE:     scale_r    <= cfg_data;
        CFG_OFFSETS:   offs_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // wrap into [-pi, pi], then fold into [-pi/2, pi/2] with a sign flip
  function automatic logic [CW:0] fold_angle(input logic signed [31:0] raw);
    logic signed [CW-1:0] a;
    logic                 neg;
    a   = CW'(raw) <<< 2;
    neg = 1'b0;
    if (a > PI_Q30) begin
      a = a - TWO_PI_Q30;
    end else if (a < -PI_Q30) begin
      a = a + TWO_PI_Q30;
    end
    if (a > HALF_PI_Q30) begin
      a   = a - PI_Q30;
      neg = 1'b1;
    end else if (a < -HALF_PI_Q30) begin
      a   = a + PI_Q30;
      neg = 1'b1;
    end
    return {neg, a};
  endfunction

  logic                 ha_neg, dc_neg;
  logic signed [CW-1:0] ha_ang, dc_ang;
  assign {ha_neg, ha_ang} = fold_angle(signed'(in_tdata[31:0]));
  assign {dc_neg, dc_ang} = fold_angle(signed'(in_tdata[63:32]));

  logic                 rh_v, rd_v, rh_neg, rd_neg;
  logic signed [CW-1:0] rh_x, rh_y, rd_x, rd_y;

  pmenc_cordic #(.STAGES(CORDIC_STAGES), .W(CW), .VECTORING(1'b0), .TAG_W(1)) u_rot_ha (
    .clk, .rst_n, .en,
    .in_valid(in_tvalid), .in_x(GAIN_Q30), .in_y('0), .in_z(ha_ang), .in_tag(ha_neg),
    .out_valid(rh_v), .out_x(rh_x), .out_y(rh_y), .out_z(), .out_tag(rh_neg)
  );

  pmenc_cordic #(.STAGES(CORDIC_STAGES), .W(CW), .VECTORING(1'b0), .TAG_W(1)) u_rot_dc (
    .clk, .rst_n, .en,
    .in_valid(in_tvalid), .in_x(GAIN_Q30), .in_y('0), .in_z(dc_ang), .in_tag(dc_neg),
    .out_valid(rd_v), .out_x(rd_x), .out_y(rd_y), .out_z(), .out_tag(rd_neg)
  );

  // stage B: unit vector
  logic signed [CW-1:0] ch_w, sh_w, cd_w, sd_w;
  logic signed [32:0]   ch, sh, cd, sd;
  logic signed [65:0]   p_cc, p_sc;
  logic signed [33:0]   b_v_r [3];
  logic                 b_vld_r;

  assign ch_w = rh_neg ? -rh_x : rh_x;
  assign sh_w = rh_neg ? -rh_y : rh_y;
  assign cd_w = rd_neg ? -rd_x : rd_x;
  assign sd_w = rd_neg ? -rd_y : rd_y;
  assign ch   = ch_w[32:0];
  assign sh   = sh_w[32:0];
  assign cd   = cd_w[32:0];
  assign sd   = sd_w[32:0];
  assign p_cc = ch * cd;
  assign p_sc = sh * cd;

  always_ff @(posedge clk) begin
    if (en) begin
      b_v_r[0] <= p_cc[63:30];
      b_v_r[1] <= p_sc[63:30];
      b_v_r[2] <= 34'(sd);
    end
  end

  // stage C: nine coefficient products
  logic [62:0]        rows [3];
  logic signed [54:0] c_p_r [3][3];
  logic               c_vld_r;

  assign rows[0] = row_x_r;
  assign rows[1] = row_y_r;
  assign rows[2] = row_z_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          c_p_r[r][j] <= signed'(rows[r][21*j +: 21]) * b_v_r[j];
        end
      end
    end
  end

  // stage D: row sums
  logic signed [56:0]   dsum [3];
  logic signed [CW-1:0] d_r [3];
  logic                 d_vld_r;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      dsum[r] = 57'(c_p_r[r][0]) + 57'(c_p_r[r][1]) + 57'(c_p_r[r][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        d_r[r] <= dsum[r][56:19];
      end
    end
  end

  // stage E: clamp z to [-1, 1] and square it
  logic signed [31:0]   zc;
  logic signed [63:0]   zz;
  logic signed [31:0]   e_zc_r;
  logic signed [CW-1:0] e_x_r, e_y_r;
  logic [60:0]          e_zz_r;
  logic                 e_vld_r;

  always_comb begin
    if (d_r[2] > ONE_Q30) begin
      zc = 32'sd1073741824;
    end else if (d_r[2] < -ONE_Q30) begin
      zc = -32'sd1073741824;
    end else begin
      zc = d_r[2][31:0];
    end
  end
  assign zz = zc * zc;

  always_ff @(posedge clk) begin
    if (en) begin
      e_zc_r <= zc;
      e_x_r  <= d_r[0];
      e_y_r  <= d_r[1];
      e_zz_r <= zz[60:0];
    end
  end

  logic                 sq_v;
  logic [30:0]          sq_root;
  logic [SQ_TAG_W-1:0]  sq_tag;
  logic signed [CW-1:0] xq, yq;
  logic signed [31:0]   zq;

  pmenc_isqrt #(.TAG_W(SQ_TAG_W)) u_isqrt (
    .clk, .rst_n, .en,
    .in_valid(e_vld_r), .in_n((61'd1 << 60) - e_zz_r), .in_tag({e_x_r, e_y_r, e_zc_r}),
    .out_valid(sq_v), .out_root(sq_root), .out_tag(sq_tag)
  );

  assign {xq, yq, zq} = sq_tag;

  // quadrant fix for the RA angle: rotate left half plane by +-pi/2
  logic signed [CW-1:0] vx, vy, vbase;
  logic [1:0]           vr_tag_in;

  always_comb begin
    vx    = xq;
    vy    = yq;
    vbase = '0;
    if (xq < 0) begin
      if (yq >= 0) begin
        vx    = yq;
        vy    = -xq;
        vbase = HALF_PI_Q30;
      end else begin
        vx    = -yq;
        vy    = xq;
        vbase = -HALF_PI_Q30;
      end
    end
  end
  // bit 1: zero radius, bit 0: y below zero
  assign vr_tag_in = {(xq == 0) && (yq == 0), yq < 0};

  logic                 vr_v, vd_v;
  logic signed [CW-1:0] vr_z, vd_z;
  logic [1:0]           vr_tag;

  pmenc_cordic #(.STAGES(CORDIC_STAGES), .W(CW), .VECTORING(1'b1), .TAG_W(2)) u_vec_ra (
    .clk, .rst_n, .en,
    .in_valid(sq_v), .in_x(vx), .in_y(vy), .in_z(vbase), .in_tag(vr_tag_in),
    .out_valid(vr_v), .out_x(), .out_y(), .out_z(vr_z), .out_tag(vr_tag)
  );

  // c is never negative, so the Dec angle needs no quadrant fix
  pmenc_cordic #(.STAGES(CORDIC_STAGES), .W(CW), .VECTORING(1'b1), .TAG_W(1)) u_vec_dc (
    .clk, .rst_n, .en,
    .in_valid(sq_v), .in_x(signed'(CW'(sq_root))), .in_y(CW'(zq)), .in_z('0), .in_tag(1'b0),
    .out_valid(vd_v), .out_x(), .out_y(), .out_z(vd_z), .out_tag()
  );

  // stage G: mirror and convert to degrees
  logic signed [CW-1:0] ra_abs, ra_ang;
  logic signed [61:0]   g_rp_r, g_dp_r;
  logic                 g_vld_r;

  always_comb begin
    ra_abs = (vr_z < 0) ? -vr_z : vr_z;
    if (vr_tag[1]) begin
      ra_abs = '0;
    end
    ra_ang = vr_tag[0] ? (TWO_PI_Q30 - ra_abs) : ra_abs;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_rp_r <= signed'(ra_ang[34:0]) * R2D_Q20;
      g_dp_r <= signed'(vd_z[34:0]) * R2D_Q20;
    end
  end

  // stage H: axis flips
  logic signed [DW-1:0] h_ra, h_dc, lim;
  logic [1:0]           h_fl;
  logic signed [DW-1:0] h_ra_r, h_dc_r;
  logic [1:0]           h_fl_r;
  logic                 h_vld_r;

  assign lim = DW'(signed'({ra_limit_r, 14'b0}));

  always_comb begin
    h_ra = DW'(signed'(g_rp_r[61:20]));
    h_dc = DW'(signed'(g_dp_r[61:20]));
    h_fl = 2'd0;
    for (int n = 0; n < 2; n++) begin
      if (h_ra > lim) begin
        h_ra = h_ra - DEG180_Q30;
        h_dc = DEG180_Q30 - h_dc;
        h_fl = h_fl + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_ra_r <= h_ra;
      h_dc_r <= h_dc;
      h_fl_r <= h_fl;
    end
  end

  // stage I: pole offset and southern inversion
  logic signed [DW-1:0] i_ra, i_dc;
  logic signed [DW-1:0] i_deg_r [2];
  logic [1:0]           i_fl_r;
  logic                 i_vld_r;

  always_comb begin
    i_ra = h_ra_r;
    i_dc = h_dc_r - DW'(signed'({pole_r, 14'b0}));
    if (south_r) begin
      if (i_dc > 0) begin
        i_dc = i_dc - DEG360_Q30;
      end
      i_ra = -i_ra;
      i_dc = -i_dc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_deg_r[0] <= i_ra;
      i_deg_r[1] <= i_dc;
      i_fl_r     <= h_fl_r;
    end
  end

  // stage J: magnitude products, split at bit 32 of the degree value
  logic signed [32:0] sc [2];
  logic [DW-1:0]      ud [2];
  logic [31:0]        us [2];
  logic               sneg [2];
  logic [63:0]        j_lo_r [2];
  logic [44:0]        j_hi_r [2];
  logic               j_neg_r [2];
  logic [1:0]         j_fl_r;
  logic               j_vld_r;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      sc[k]   = 33'(signed'(scale_r[32*k +: 32]));
      sneg[k] = (i_deg_r[k] < 0) != (sc[k] < 0);
      ud[k]   = (i_deg_r[k] < 0) ? DW'(-i_deg_r[k]) : DW'(i_deg_r[k]);
      us[k]   = (sc[k] < 0) ? 32'(-sc[k]) : 32'(sc[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        j_lo_r[k]  <= ud[k][31:0] * us[k];
        j_hi_r[k]  <= 45'(ud[k][DW-1:32]) * 45'(us[k]);
        j_neg_r[k] <= sneg[k];
      end
      j_fl_r <= i_fl_r;
    end
  end

  // stage K: shift down, sign, offset, saturate; q stays below 2^32 so no 2^40 ceiling
  logic [45:0]        qsum [2];
  logic signed [33:0] qs [2];
  logic signed [34:0] rsum [2];
  logic [31:0]        enc [2];
  logic [71:0]        out_tdata_r;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      qsum[k] = 46'(j_hi_r[k]) + 46'(j_lo_r[k][63:32]);
      qs[k]   = j_neg_r[k] ? -signed'({2'b00, qsum[k][45:14]})
                           : signed'({2'b00, qsum[k][45:14]});
      rsum[k] = 35'(qs[k]) + 35'(signed'(offs_r[32*k +: 32]));
      if (rsum[k] > 35'sd2147483647) begin
        enc[k] = 32'h7FFF_FFFF;
      end else if (rsum[k] < -35'sd2147483648) begin
        enc[k] = 32'h8000_0000;
      end else begin
        enc[k] = rsum[k][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= {6'b0, j_fl_r, enc[1], enc[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      d_vld_r     <= 1'b0;
      e_vld_r     <= 1'b0;
      g_vld_r     <= 1'b0;
      h_vld_r     <= 1'b0;
      i_vld_r     <= 1'b0;
      j_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      b_vld_r     <= rh_v;
      c_vld_r     <= b_vld_r;
      d_vld_r     <= c_vld_r;
      e_vld_r     <= d_vld_r;
      g_vld_r     <= vr_v;
      h_vld_r     <= g_vld_r;
      i_vld_r     <= h_vld_r;
      j_vld_r     <= i_vld_r;
      out_valid_r <= j_vld_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  `PM_ASSERT_ALWAYS(a_rot_align, rh_v == rd_v, "sin/cos lanes out of step")
  `PM_ASSERT_ALWAYS(a_vec_align, vr_v == vd_v, "angle lanes out of step")
  `PM_ASSERT_IMPL(a_flip_range, out_tvalid, out_tdata[65:64] != 2'd3, "more than two flips")

endmodule

@@ hw/rtl/pmenc_cordic.sv @@
module pmenc_cordic #(
  parameter int STAGES    = 24,
  parameter int W         = 38,
  parameter bit VECTORING = 1'b0,
  parameter int TAG_W     = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [W-1:0] in_x,
  input  logic signed [W-1:0] in_y,
  input  logic signed [W-1:0] in_z,
  input  logic [TAG_W-1:0]    in_tag,
  output logic                out_valid,
  output logic signed [W-1:0] out_x,
  output logic signed [W-1:0] out_y,
  output logic signed [W-1:0] out_z,
  output logic [TAG_W-1:0]    out_tag
);
  import pmenc_pkg::*;

  logic signed [W-1:0] x_r [STAGES+1];
  logic signed [W-1:0] y_r [STAGES+1];
  logic signed [W-1:0] z_r [STAGES+1];
  logic [TAG_W-1:0]    tag_r [STAGES+1];
  logic [STAGES:0]     vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STAGES-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= in_x;
      y_r[0]   <= in_y;
      z_r[0]   <= in_z;
      tag_r[0] <= in_tag;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic                rot_pos;
    logic signed [W-1:0] xs;
    logic signed [W-1:0] ys;
    logic signed [W-1:0] at;

    // vectoring drives y toward zero, rotation drives z toward zero
    assign rot_pos = VECTORING ? (y_r[i] < 0) : (z_r[i] >= 0);
    assign xs      = x_r[i] >>> i;
    assign ys      = y_r[i] >>> i;
    assign at      = signed'(W'(atan_q30(i)));

    always_ff @(posedge clk) begin
      if (en) begin
        if (rot_pos) begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - at;
        end else begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + at;
        end
        tag_r[i+1] <= tag_r[i];
      end
    end
  end

  assign out_valid = vld_r[STAGES];
  assign out_x     = x_r[STAGES];
  assign out_y     = y_r[STAGES];
  assign out_z     = z_r[STAGES];
  assign out_tag   = tag_r[STAGES];

endmodule

@@ hw/rtl/pmenc_isqrt.sv @@
module pmenc_isqrt #(
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [60:0]      in_n,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [30:0]      out_root,
  output logic [TAG_W-1:0] out_tag
);
  localparam int STEPS = 31;
  localparam int NW    = 62;

  logic [NW-1:0]    n_r   [STEPS+1];
  logic [NW-1:0]    res_r [STEPS+1];
  logic [TAG_W-1:0] tag_r [STEPS+1];
  logic [STEPS:0]   vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STEPS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]   <= NW'(in_n);
      res_r[0] <= '0;
      tag_r[0] <= in_tag;
    end
  end

  // one result bit per stage, trial bit walks down two places at a time
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [NW-1:0] BIT = {{(NW-1){1'b0}}, 1'b1} << (60 - 2 * k);
    logic [NW-1:0] trial;

    assign trial = res_r[k] + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (n_r[k] >= trial) begin
          n_r[k+1]   <= n_r[k] - trial;
          res_r[k+1] <= (res_r[k] >> 1) + BIT;
        end else begin
          n_r[k+1]   <= n_r[k];
          res_r[k+1] <= res_r[k] >> 1;
        end
        tag_r[k+1] <= tag_r[k];
      end
    end
  end

  assign out_valid = vld_r[STEPS];
  assign out_root  = res_r[STEPS][30:0];
  assign out_tag   = tag_r[STEPS];

endmodule
